// ===== hw/rtl/fprb_pkg.sv =====
package fprb_pkg;

    localparam int RING_DEPTH  = 32;
    localparam int HANDLE_BITS = 32;

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    typedef logic [HANDLE_BITS-1:0] t_handle;

    typedef struct packed {
        logic               cmd;
        logic [31:0]        frame_handle;
        logic signed [63:0] frame_time;
        logic signed [63:0] now_time;
    } t_in_item;

    typedef struct packed {
        logic               current_valid;
        logic [31:0]        current_handle;
        logic signed [63:0] current_time;
    } t_out_item;

    // commands from the controller to the datapath
    typedef struct packed {
        logic push;
        logic load_now;
        logic anchor;
        logic diff;
        logic target;
        logic pop;
    } t_ctrl_cmd;

    // status from the datapath back to the controller
    typedef struct packed {
        logic empty;
        logic due;
    } t_dp_status;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_ANCHOR = 6'b000100,
        S_DIFF   = 6'b001000,
        S_TARGET = 6'b010000,
        S_SCAN   = 6'b100000
    } t_state;

    function automatic t_handle to_handle(input logic [31:0] h);
        logic [HANDLE_BITS+31:0] wide;
        wide = {{HANDLE_BITS{1'b0}}, h};
        return wide[HANDLE_BITS-1:0];
    endfunction

    function automatic logic [31:0] from_handle(input t_handle h);
        logic [HANDLE_BITS+31:0] wide;
        wide = {32'd0, h};
        return wide[31:0];
    endfunction

endpackage

// ===== hw/rtl/fprb_ctrl.sv =====
module fprb_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  logic                   i_cmd,
    input  fprb_pkg::t_dp_status   i_status,
    output fprb_pkg::t_ctrl_cmd    o_cmd,
    output logic                   busy,
    output logic                   o_strobe
);

    fprb_pkg::t_state r_state, n_state;
    logic             r_strobe, n_strobe;
    logic             accept;
    logic             pop_now;

    assign busy    = (r_state != fprb_pkg::S_IDLE);
    assign accept  = start && !busy;
    assign pop_now = (r_state == fprb_pkg::S_SCAN) && !i_status.empty && i_status.due;

    always_comb begin
        o_cmd          = '0;
        o_cmd.push     = accept && (i_cmd == fprb_pkg::CMD_PUSH);
        o_cmd.load_now = accept && (i_cmd == fprb_pkg::CMD_FETCH);
        o_cmd.anchor   = (r_state == fprb_pkg::S_ANCHOR);
        o_cmd.diff     = (r_state == fprb_pkg::S_DIFF);
        o_cmd.target   = (r_state == fprb_pkg::S_TARGET);
        o_cmd.pop      = pop_now;
    end

    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        case (r_state)
            fprb_pkg::S_IDLE: begin
                if (accept && (i_cmd == fprb_pkg::CMD_FETCH)) begin
                    n_state = fprb_pkg::S_READ;
                end
            end
            fprb_pkg::S_READ:   n_state = fprb_pkg::S_ANCHOR;
            fprb_pkg::S_ANCHOR: n_state = fprb_pkg::S_DIFF;
            fprb_pkg::S_DIFF:   n_state = fprb_pkg::S_TARGET;
            fprb_pkg::S_TARGET: n_state = fprb_pkg::S_SCAN;
            fprb_pkg::S_SCAN: begin
                // one entry per cycle until the ring is empty or the head is not yet due
                if (!pop_now) begin
                    n_state  = fprb_pkg::S_IDLE;
                    n_strobe = 1'b1;
                end
            end
            default: n_state = fprb_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fprb_pkg::S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    assign o_strobe = r_strobe;

endmodule

// ===== hw/rtl/fprb_dp.sv =====
module fprb_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_wdata,
    input  fprb_pkg::t_in_item     i_item,
    input  fprb_pkg::t_ctrl_cmd    i_cmd,
    output fprb_pkg::t_dp_status   o_status,
    output fprb_pkg::t_out_item    o_result
);

    localparam int IDX_W = fprb_pkg::IDX_W;
    localparam int CNT_W = fprb_pkg::CNT_W;
    localparam int SUM_W = fprb_pkg::SUM_W;
    localparam int DEPTH = fprb_pkg::RING_DEPTH;

    fprb_pkg::t_handle mem_handle [DEPTH];
    logic [63:0]       mem_time   [DEPTH];

    logic              r_enable;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_anchored;
    logic [63:0]       r_anchor_media;
    logic [63:0]       r_anchor_sys;
    logic [63:0]       r_now;
    logic [63:0]       r_target;
    fprb_pkg::t_handle r_sel_handle;
    logic [63:0]       r_sel_time;
    fprb_pkg::t_handle r_rd_handle;
    logic [63:0]       r_rd_time;

    fprb_pkg::t_handle in_handle;
    logic              full;
    logic              push_ok;
    logic [SUM_W-1:0]  tail_sum;
    logic [IDX_W-1:0]  tail;
    logic [IDX_W-1:0]  head_inc;

    assign in_handle = fprb_pkg::to_handle(i_item.frame_handle);
    assign full      = (r_count == CNT_W'(DEPTH));
    assign push_ok   = i_cmd.push && (in_handle != '0) && r_enable;
    assign head_inc  = (r_head == IDX_W'(DEPTH - 1)) ? '0 : r_head + IDX_W'(1);

    // a full ring drops its oldest entry, so the new one lands on the old head
    always_comb begin
        tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
        if (tail_sum >= SUM_W'(DEPTH)) begin
            tail_sum = tail_sum - SUM_W'(DEPTH);
        end
        tail = full ? r_head : tail_sum[IDX_W-1:0];
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (push_ok) begin
            if (full) begin
                n_head = head_inc;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else if (i_cmd.pop) begin
            n_head  = head_inc;
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            mem_handle[tail] <= in_handle;
            mem_time[tail]   <= i_item.frame_time;
        end
        // read follows the head as it will be after this edge
        r_rd_handle <= mem_handle[n_head];
        r_rd_time   <= mem_time[n_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable       <= 1'b1;
            r_head         <= '0;
            r_count        <= '0;
            r_anchored     <= 1'b0;
            r_anchor_media <= '0;
            r_anchor_sys   <= '0;
            r_sel_handle   <= '0;
            r_sel_time     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cmd.anchor && !r_anchored && (r_count != '0)) begin
                r_anchored     <= 1'b1;
                r_anchor_media <= r_rd_time;
                r_anchor_sys   <= r_now;
            end
            if (i_cmd.pop) begin
                r_sel_handle <= r_rd_handle;
                r_sel_time   <= r_rd_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_now) begin
            r_now <= i_item.now_time;
        end
        if (i_cmd.diff) begin
            r_target <= r_now - r_anchor_sys;
        end else if (i_cmd.target) begin
            r_target <= r_anchor_media + r_target;
        end
    end

    assign o_status.empty = (r_count == '0);
    assign o_status.due   = ($signed(r_rd_time) <= $signed(r_target));

    assign o_result.current_valid  = (r_sel_handle != '0);
    assign o_result.current_handle = fprb_pkg::from_handle(r_sel_handle);
    assign o_result.current_time   = r_sel_time;

endmodule

// ===== hw/rtl/frame_pacing_ring_buffer.sv =====
// frame pacing ring buffer: a ring of timestamped frame handles that drops the
// oldest entry when full and paces them out against system time.
// an item is taken at a clock edge with start high and busy low. a push
// (cmd 0) is written in that same cycle and gives no result; busy stays low.
// a fetch (cmd 1) raises busy through the read, anchor, diff and target
// states and a scan loop that pops k entries (0 to ring depth), one ring
// read per cycle, until the ring is empty or its head is not yet due.
// the result appears on o_result with o_strobe high for exactly one cycle,
// in the same cycle that busy falls. the receiver cannot stall; the strobe
// is the only beat marker and must be taken when it shows.
// the configuration port writes buffer_enable at any edge with i_cfg_we high;
// only change it while the block is idle; the block does not enforce this.
// synchronous reset clears the ring pointers, anchor and current frame and sets
// buffer_enable to 1; ring contents are not cleared and no clearing pass runs.
module frame_pacing_ring_buffer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  fprb_pkg::t_in_item   i_item,
    output logic                 o_strobe,
    output fprb_pkg::t_out_item  o_result,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata
);

    fprb_pkg::t_ctrl_cmd  ctrl_cmd;
    fprb_pkg::t_dp_status dp_status;

    fprb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_item.cmd),
        .i_status (dp_status),
        .o_cmd    (ctrl_cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    fprb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .i_cmd       (ctrl_cmd),
        .o_status    (dp_status),
        .o_result    (o_result)
    );

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held longer than one cycle");

    a_strobe_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a fetch in progress");

    a_fetch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.cmd == fprb_pkg::CMD_FETCH)) |=> busy)
        else $error("fetch accepted but block not busy");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_status.empty |-> !ctrl_cmd.pop)
        else $error("pop issued on an empty ring");

endmodule

// ===== test/frame_pacing_ring_buffer_tb.sv =====
`timescale 1ns / 1ps

module frame_pacing_ring_buffer_tb;

    localparam int                 STALL_LIMIT = 2000;
    localparam int                 END_DRAIN   = 40;
    localparam logic signed [63:0] TIME_MIN    = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] TIME_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    fprb_pkg::t_in_item  i_item;
    logic                o_strobe;
    fprb_pkg::t_out_item o_result;
    logic                i_cfg_we;
    logic                i_cfg_wdata;

    frame_pacing_ring_buffer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // pacer state kept alongside the block
    logic [31:0]        ring_handle [fprb_pkg::RING_DEPTH];
    logic signed [63:0] ring_stamp  [fprb_pkg::RING_DEPTH];
    int                 head;
    int                 fill;
    bit                 anchored;
    logic signed [63:0] anchor_media;
    logic signed [63:0] anchor_sys;
    logic [31:0]        sel_handle;
    logic signed [63:0] sel_time;
    bit                 buf_en;

    fprb_pkg::t_out_item due_frames_q [$];
    logic signed [63:0]  stream_pts;

    int err_count = 0;
    int stored_count;
    int ignored_count;
    int fetch_count;
    int pop_count;
    int overflow_count;
    int stall_cycles;

    task automatic advance_pacer(input fprb_pkg::t_in_item it);
        int                  tail;
        logic signed [63:0]  target;
        fprb_pkg::t_out_item res;
        if (it.cmd == fprb_pkg::CMD_PUSH) begin
            if (it.frame_handle == 32'd0 || !buf_en) begin
                ignored_count++;
            end else begin
                stored_count++;
                // drop the oldest entry to make room
                if (fill >= fprb_pkg::RING_DEPTH) begin
                    head = (head + 1) % fprb_pkg::RING_DEPTH;
                    fill = fprb_pkg::RING_DEPTH - 1;
                    overflow_count++;
                end
                tail = (head + fill) % fprb_pkg::RING_DEPTH;
                ring_handle[tail] = it.frame_handle;
                ring_stamp[tail]  = it.frame_time;
                fill++;
            end
        end else begin
            fetch_count++;
            if (!anchored && fill > 0) begin
                anchor_media = ring_stamp[head];
                anchor_sys   = it.now_time;
                anchored     = 1'b1;
            end
            if (anchored) begin
                target = anchor_media + (it.now_time - anchor_sys);
                while (fill > 0 && ring_stamp[head] <= target) begin
                    sel_handle = ring_handle[head];
                    sel_time   = ring_stamp[head];
                    head       = (head + 1) % fprb_pkg::RING_DEPTH;
                    fill--;
                    pop_count++;
                end
            end
            res.current_valid  = (sel_handle != 32'd0);
            res.current_handle = sel_handle;
            res.current_time   = sel_time;
            due_frames_q.push_back(res);
        end
    endtask

    // system time whose anchored target lands on the given media time
    function automatic logic signed [63:0] now_for_target(input logic signed [63:0] want);
        return anchor_sys + (want - anchor_media);
    endfunction

    function automatic fprb_pkg::t_in_item beat(input logic cmd, input logic [31:0] handle,
                                                input logic signed [63:0] ftime,
                                                input logic signed [63:0] now);
        fprb_pkg::t_in_item it;
        it.cmd          = cmd;
        it.frame_handle = handle;
        it.frame_time   = ftime;
        it.now_time     = now;
        return it;
    endfunction

    function automatic fprb_pkg::t_in_item random_frame_beat();
        fprb_pkg::t_in_item it;
        int unsigned        pick;
        int unsigned        how;
        int                 k;
        logic signed [63:0] want;
        it.cmd          = 1'($urandom_range(0, 1));
        it.frame_handle = $urandom;
        it.frame_time   = {$urandom, $urandom};
        it.now_time     = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            // noise: random command and fields
        end else if (pick < 58) begin
            it.cmd = fprb_pkg::CMD_PUSH;
            if ($urandom_range(0, 19) == 0)
                it.frame_handle = 32'd0;
            else if (it.frame_handle == 32'd0)
                it.frame_handle = 32'd1;
            stream_pts    = stream_pts + $urandom_range(1, 50000);
            it.frame_time = stream_pts;
        end else begin
            it.cmd = fprb_pkg::CMD_FETCH;
            if (anchored && fill > 0) begin
                how  = $urandom_range(0, 9);
                k    = $urandom_range(0, fill - 1);
                want = ring_stamp[(head + k) % fprb_pkg::RING_DEPTH];
                if (how >= 5 && how < 8)
                    want = want - 1;
                else if (how == 8)
                    want = want + $urandom_range(0, 1000);
                else if (how == 9)
                    want = TIME_MAX;
                it.now_time = now_for_target(want);
            end else if (anchored) begin
                it.now_time = now_for_target(sel_time + $urandom_range(0, 100000));
            end
        end
        return it;
    endfunction

    task automatic send_beat(input fprb_pkg::t_in_item it);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        advance_pacer(it);
    endtask

    // each cycle the sender stays idle with the given chance in a hundred
    task automatic sender_gap(input int pct);
        while ($urandom_range(0, 99) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // hold the sender until every fetch has answered, then let the block settle
    task automatic wait_for_results();
        if (start)
            start <= 1'b0;
        do @(posedge i_clk); while (due_frames_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_buffer_enable(input logic value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        buf_en = value;
    endtask

    task automatic run_traffic(input int count, input int pct);
        fprb_pkg::t_in_item it;
        int                 done;
        done = 0;
        while (done < count) begin
            it = random_frame_beat();
            done++;
            send_beat(it);
            if ($urandom_range(0, 199) == 0)
                wait_for_results();
            else
                sender_gap(pct);
        end
    endtask

    task automatic test_fetch_before_frames();
        send_beat(beat(fprb_pkg::CMD_FETCH, 32'h0, 64'sd0, TIME_MIN));
        send_beat(beat(fprb_pkg::CMD_FETCH, 32'hFFFF_FFFF, -64'sd1, TIME_MAX));
    endtask

    task automatic test_push_extremes_and_wrap();
        send_beat(beat(fprb_pkg::CMD_PUSH, 32'h0, TIME_MAX, 64'sd0));
        send_beat(beat(fprb_pkg::CMD_PUSH, 32'hFFFF_FFFF, TIME_MIN, TIME_MAX));
        send_beat(beat(fprb_pkg::CMD_PUSH, 32'h0000_0001, TIME_MAX, TIME_MIN));
        // anchors on the oldest frame at the most negative time
        send_beat(beat(fprb_pkg::CMD_FETCH, 32'h0, 64'sd0, 64'sd5));
        // now one below the anchor wraps the target round to the top
        send_beat(beat(fprb_pkg::CMD_FETCH, 32'h0, 64'sd0, 64'sd4));
        send_beat(beat(fprb_pkg::CMD_FETCH, 32'h0, 64'sd0, TIME_MIN));
    endtask

    task automatic test_enable_gating();
        send_beat(beat(fprb_pkg::CMD_PUSH, 32'hA5A5_0001, 64'sd100, 64'sd0));
        wait_for_results();
        set_buffer_enable(1'b0);
        send_beat(beat(fprb_pkg::CMD_PUSH, 32'h0000_0002, 64'sd50, 64'sd0));
        // held entry still pops while disabled
        send_beat(beat(fprb_pkg::CMD_FETCH, 32'h0, 64'sd0, now_for_target(64'sd100)));
        send_beat(beat(fprb_pkg::CMD_FETCH, 32'h0, 64'sd0, now_for_target(64'sd200)));
        wait_for_results();
        set_buffer_enable(1'b1);
        send_beat(beat(fprb_pkg::CMD_PUSH, 32'h0000_0003, 64'sd300, 64'sd0));
        send_beat(beat(fprb_pkg::CMD_FETCH, 32'h0, 64'sd0, now_for_target(64'sd299)));
        send_beat(beat(fprb_pkg::CMD_FETCH, 32'h0, 64'sd0, now_for_target(64'sd300)));
    endtask

    task automatic test_ring_overflow();
        for (int i = 0; i < fprb_pkg::RING_DEPTH + 4; i++)
            send_beat(beat(fprb_pkg::CMD_PUSH, 32'h100 + i,
                           64'sd1_000_000 + 1000 * i, 64'sd0));
        send_beat(beat(fprb_pkg::CMD_FETCH, 32'h0, 64'sd0,
                       now_for_target(ring_stamp[(head + 2) % fprb_pkg::RING_DEPTH])));
        send_beat(beat(fprb_pkg::CMD_FETCH, 32'h0, 64'sd0, now_for_target(TIME_MAX)));
    endtask

    task automatic test_random_traffic();
        stream_pts = 64'sh7FFF_FFFF_FF00_0000;
        run_traffic(600, 34);
        wait_for_results();
        set_buffer_enable(1'b0);
        run_traffic(120, 59);
        wait_for_results();
        set_buffer_enable(1'b1);
        run_traffic(430, 59);
        wait_for_results();
        run_traffic(550, 0);
    endtask

    always @(posedge i_clk) begin : check_beat
        fprb_pkg::t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (due_frames_q.size() == 0) begin
                $error("result beat with no fetch pending: handle %h time %0d",
                       o_result.current_handle, o_result.current_time);
                err_count++;
            end else begin
                want = due_frames_q.pop_front();
                if (o_result.current_valid !== want.current_valid) begin
                    $error("current_valid: expected %0d, got %0d",
                           want.current_valid, o_result.current_valid);
                    err_count++;
                end
                if (o_result.current_handle !== want.current_handle) begin
                    $error("current_handle: expected %h, got %h",
                           want.current_handle, o_result.current_handle);
                    err_count++;
                end
                if (o_result.current_time !== want.current_time) begin
                    $error("current_time: expected %0d, got %0d",
                           want.current_time, o_result.current_time);
                    err_count++;
                end
            end
        end
    end

    // count cycles with no beat moving in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL frame_pacing_ring_buffer");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_item       <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= 1'b0;
        stored_count  = 0;
        ignored_count = 0;
        fetch_count   = 0;
        pop_count     = 0;
        overflow_count = 0;
        head         = 0;
        fill         = 0;
        anchored     = 1'b0;
        anchor_media = '0;
        anchor_sys   = '0;
        sel_handle   = '0;
        sel_time     = '0;
        buf_en       = 1'b1;
        stream_pts   = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fetch_before_frames();
        test_push_extremes_and_wrap();
        test_enable_gating();
        test_ring_overflow();
        test_random_traffic();

        wait_for_results();
        repeat (END_DRAIN) @(posedge i_clk);

        $display("covered %0d stored pushes, %0d ignored pushes, %0d fetches, %0d frames popped",
                 stored_count, ignored_count, fetch_count, pop_count);
        $display("with %0d drop-oldest overflows, time wrap, and buffering switched off and on",
                 overflow_count);
        if (err_count == 0)
            $display("PASS frame_pacing_ring_buffer");
        else
            $display("FAIL frame_pacing_ring_buffer");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/fprb_pkg.sv
hw/rtl/fprb_ctrl.sv
hw/rtl/fprb_dp.sv
hw/rtl/frame_pacing_ring_buffer.sv
test/frame_pacing_ring_buffer_tb.sv
